FILE: rtl/core/tisn_pkg.sv
// Shared constants and types for the top-four influence selection and normalization block.
package tisn_pkg;

   localparam int JOINT_W           = 16;
   localparam int WEIGHT_W          = 16;
   localparam int OUT_SLOTS         = 4;
   localparam int TOP_SLOTS_DEFAULT = 4;
   localparam int QUEUE_DEPTH       = 2;
   localparam int MIN_SUM_W         = 18;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_INDEX_W       = CSR_ADDR_W - 2;

   localparam logic [WEIGHT_W-1:0]    ONE_Q15            = 16'h8000;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SUM_INDEX  = 1'b0;

   typedef struct packed {
      logic [OUT_SLOTS-1:0][JOINT_W-1:0]  joints;
      logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] weights;
   } vertex_type;

endpackage

FILE: rtl/core/tisn_req_if.sv
// Input channel carrying one influence item per handshake.
interface tisn_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] joint_id;
   logic [15:0] influence_weight;
   logic        last_influence;

   modport source (output valid, joint_id, influence_weight, last_influence, input ready);
   modport sink (input valid, joint_id, influence_weight, last_influence, output ready);
endinterface

FILE: rtl/core/tisn_rsp_if.sv
// Result channel carrying one normalized vertex item per handshake.
interface tisn_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] joint_0;
   logic [15:0] joint_1;
   logic [15:0] joint_2;
   logic [15:0] joint_3;
   logic [15:0] norm_weight_0;
   logic [15:0] norm_weight_1;
   logic [15:0] norm_weight_2;
   logic [15:0] norm_weight_3;

   modport source (output valid, joint_0, joint_1, joint_2, joint_3,
                   norm_weight_0, norm_weight_1, norm_weight_2, norm_weight_3,
                   input ready);
   modport sink (input valid, joint_0, joint_1, joint_2, joint_3,
                 norm_weight_0, norm_weight_1, norm_weight_2, norm_weight_3,
                 output ready);
endinterface

FILE: rtl/core/tisn_front.sv
// Front end: sorted insertion of influences and running weight sum per vertex.
module tisn_front #(
   parameter int TOP_SLOTS = 4,
   parameter int SUM_W     = 18
) (
   input  logic                clock,
   input  logic                reset,
   tisn_req_if.sink            req,
   output logic                push_valid,
   input  logic                push_ready,
   output tisn_pkg::vertex_type push_rec,
   output logic [SUM_W-1:0]    push_sum
);
   import tisn_pkg::*;

   logic [JOINT_W-1:0]  joint_ff [TOP_SLOTS];
   logic [WEIGHT_W-1:0] weight_ff [TOP_SLOTS];
   logic [JOINT_W-1:0]  joint_in [TOP_SLOTS];
   logic [WEIGHT_W-1:0] weight_in [TOP_SLOTS];
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [WEIGHT_W-1:0] w_sat;
   logic [TOP_SLOTS-1:0] greater;
   logic                accept;

   assign w_sat  = (req.influence_weight > ONE_Q15) ? ONE_Q15 : req.influence_weight;
   assign accept = req.valid && req.ready;

   always_comb begin
      for (int i = 0; i < TOP_SLOTS; i++) begin
         greater[i] = w_sat > weight_ff[i];
      end
      for (int i = 0; i < TOP_SLOTS; i++) begin
         if (!greater[i]) begin
            joint_in[i]  = joint_ff[i];
            weight_in[i] = weight_ff[i];
         end else if (i == 0) begin
            joint_in[i]  = req.joint_id;
            weight_in[i] = w_sat;
         end else if (!greater[(i == 0) ? 0 : i - 1]) begin
            joint_in[i]  = req.joint_id;
            weight_in[i] = w_sat;
         end else begin
            joint_in[i]  = joint_ff[(i == 0) ? 0 : i - 1];
            weight_in[i] = weight_ff[(i == 0) ? 0 : i - 1];
         end
      end
      if (greater[TOP_SLOTS-1]) begin
         sum_in = sum_ff + SUM_W'(w_sat) - SUM_W'(weight_ff[TOP_SLOTS-1]);
      end else begin
         sum_in = sum_ff;
      end
   end

   for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_rec
      if (k < TOP_SLOTS) begin : g_kept
         assign push_rec.joints[k]  = joint_in[k];
         assign push_rec.weights[k] = weight_in[k];
      end else begin : g_absent
         assign push_rec.joints[k]  = '0;
         assign push_rec.weights[k] = '0;
      end
   end

   assign req.ready  = push_ready;
   assign push_valid = req.valid && req.last_influence;
   assign push_sum   = sum_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && req.last_influence)) begin
         for (int i = 0; i < TOP_SLOTS; i++) begin
            joint_ff[i]  <= '0;
            weight_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (accept) begin
         for (int i = 0; i < TOP_SLOTS; i++) begin
            joint_ff[i]  <= joint_in[i];
            weight_ff[i] <= weight_in[i];
         end
         sum_ff <= sum_in;
      end
   end

endmodule

FILE: rtl/core/tisn_queue.sv
// Short queue of finished vertex lists between the front and back ends.
module tisn_queue #(
   parameter int SUM_W = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  tisn_pkg::vertex_type push_rec,
   input  logic [SUM_W-1:0]     push_sum,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output tisn_pkg::vertex_type pop_rec,
   output logic [SUM_W-1:0]     pop_sum
);
   import tisn_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   vertex_type       rec_ff [QUEUE_DEPTH];
   logic [SUM_W-1:0] sum_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_rec    = rec_ff[rd_ptr_ff];
   assign pop_sum    = sum_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         rec_ff[wr_ptr_ff] <= push_rec;
         sum_ff[wr_ptr_ff] <= push_sum;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/core/tisn_back.sv
// Back end: threshold check, shared bit-serial divider and result register.
module tisn_back #(
   parameter int SUM_W = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tisn_pkg::MIN_SUM_W-1:0]   min_weight_sum,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  tisn_pkg::vertex_type             pop_rec,
   input  logic [SUM_W-1:0]                 pop_sum,
   tisn_rsp_if.source                       rsp
);
   import tisn_pkg::*;

   localparam int QUO_W  = WEIGHT_W;
   localparam int STEP_W = $clog2(QUO_W);
   localparam int SLOT_W = $clog2(OUT_SLOTS);
   localparam int CMP_W  = (SUM_W > MIN_SUM_W) ? SUM_W : MIN_SUM_W;

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_DONE} state_type;

   state_type                          state_ff;
   logic [SLOT_W-1:0]                  slot_ff;
   logic [STEP_W-1:0]                  step_ff;
   logic [SUM_W-1:0]                   rem_ff;
   logic [QUO_W-1:0]                   quo_ff;
   logic [SUM_W-1:0]                   sum_ff;
   vertex_type                         rec_ff;
   logic [OUT_SLOTS-1:0][JOINT_W-1:0]  res_joint_ff;
   logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] res_weight_ff;
   logic                               out_valid_ff;
   logic [OUT_SLOTS-1:0][JOINT_W-1:0]  out_joint_ff;
   logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] out_weight_ff;

   logic [WEIGHT_W-1:0] cur_w;
   logic [WEIGHT_W-1:0] next_w;
   logic                in_bit;
   logic [SUM_W:0]      trial;
   logic [SUM_W:0]      diff;
   logic                fits;
   logic [SUM_W-1:0]    rem_in;
   logic [QUO_W-1:0]    quo_in;
   logic                fallback;
   logic                out_free;

   always_comb begin
      cur_w    = rec_ff.weights[slot_ff];
      next_w   = rec_ff.weights[SLOT_W'(slot_ff + 1'b1)];
      in_bit   = (step_ff == '0) ? cur_w[0] : 1'b0;
      trial    = {rem_ff, in_bit};
      diff     = trial - {1'b0, sum_ff};
      fits     = trial >= {1'b0, sum_ff};
      rem_in   = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quo_in   = {quo_ff[QUO_W-2:0], fits};
      fallback = CMP_W'(pop_sum) <= CMP_W'(min_weight_sum);
      out_free = !out_valid_ff || rsp.ready;
   end

   assign pop_ready         = state_ff == ST_IDLE;
   assign rsp.valid         = out_valid_ff;
   assign rsp.joint_0       = out_joint_ff[0];
   assign rsp.joint_1       = out_joint_ff[1];
   assign rsp.joint_2       = out_joint_ff[2];
   assign rsp.joint_3       = out_joint_ff[3];
   assign rsp.norm_weight_0 = out_weight_ff[0];
   assign rsp.norm_weight_1 = out_weight_ff[1];
   assign rsp.norm_weight_2 = out_weight_ff[2];
   assign rsp.norm_weight_3 = out_weight_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         slot_ff      <= '0;
         step_ff      <= '0;
      end else begin
         if (state_ff == ST_DONE && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  rec_ff  <= pop_rec;
                  sum_ff  <= pop_sum;
                  slot_ff <= '0;
                  step_ff <= '0;
                  rem_ff  <= SUM_W'(pop_rec.weights[0][WEIGHT_W-1:1]);
                  quo_ff  <= '0;
                  if (fallback) begin
                     res_joint_ff  <= '0;
                     res_weight_ff <= (OUT_SLOTS * WEIGHT_W)'(ONE_Q15);
                     state_ff      <= ST_DONE;
                  end else begin
                     res_joint_ff <= pop_rec.joints;
                     state_ff     <= ST_DIVIDE;
                  end
               end
            end
            ST_DIVIDE: begin
               if (step_ff == STEP_W'(QUO_W - 1)) begin
                  res_weight_ff[slot_ff] <= quo_in;
                  step_ff                <= '0;
                  if (slot_ff == SLOT_W'(OUT_SLOTS - 1)) begin
                     state_ff <= ST_DONE;
                  end else begin
                     slot_ff <= slot_ff + 1'b1;
                     rem_ff  <= SUM_W'(next_w[WEIGHT_W-1:1]);
                     quo_ff  <= '0;
                  end
               end else begin
                  rem_ff  <= rem_in;
                  quo_ff  <= quo_in;
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  out_joint_ff  <= res_joint_ff;
                  out_weight_ff <= res_weight_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/top4_influence_select_normalize.sv
// Top level: selects the four strongest influences of a vertex and normalizes their weights.
// Influence items are taken one per cycle by the sorting front end while the queue has room.
// Results pass the queue, the divisions and the result register; fallback skips division.
// The back end handles one vertex at a time: four 16-step divisions on one divider.
// A two-entry queue lets the front end collect the next vertices while the divider runs.
// Synchronous active-high reset empties the list, the queue and the result register,
// and sets min_weight_sum to zero.
module top4_influence_select_normalize #(
   parameter int TOP_SLOTS = tisn_pkg::TOP_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tisn_req_if.sink                        req_item,
   tisn_rsp_if.source                      rsp_item,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tisn_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tisn_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tisn_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import tisn_pkg::*;

   localparam int SUM_W = $clog2(TOP_SLOTS * 32768 + 1);

   logic [MIN_SUM_W-1:0]   min_sum_ff;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   push_valid;
   logic                   push_ready;
   vertex_type             push_rec;
   logic [SUM_W-1:0]       push_sum;
   logic                   pop_valid;
   logic                   pop_ready;
   vertex_type             pop_rec;
   logic [SUM_W-1:0]       pop_sum;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == CSR_MIN_SUM_INDEX) ? CSR_DATA_W'(min_sum_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sum_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_index == CSR_MIN_SUM_INDEX) begin
         min_sum_ff <= csr_pwdata[MIN_SUM_W-1:0];
      end
   end

   tisn_front #(
      .TOP_SLOTS (TOP_SLOTS),
      .SUM_W     (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .push_sum   (push_sum)
   );

   tisn_queue #(
      .SUM_W (SUM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .push_sum   (push_sum),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec),
      .pop_sum    (pop_sum)
   );

   tisn_back #(
      .SUM_W (SUM_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .min_weight_sum (min_sum_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_rec        (pop_rec),
      .pop_sum        (pop_sum),
      .rsp            (rsp_item)
   );

endmodule

FILE: rtl/core/tisn_checker.sv
// Port-level checks on the result channel, bound to the top level.
module tisn_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] joint_1,
   input logic [15:0] joint_2,
   input logic [15:0] joint_3,
   input logic [15:0] norm_weight_0,
   input logic [15:0] norm_weight_1,
   input logic [15:0] norm_weight_2,
   input logic [15:0] norm_weight_3
);
   import tisn_pkg::*;

   logic [17:0] weight_total;

   assign weight_total = 18'(norm_weight_0) + 18'(norm_weight_1)
                       + 18'(norm_weight_2) + 18'(norm_weight_3);

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result item dropped while stalled.");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> norm_weight_0 >= norm_weight_1 && norm_weight_1 >= norm_weight_2
                    && norm_weight_2 >= norm_weight_3)
      else $error("Normalized weights are not in descending order.");

   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> weight_total <= 18'(ONE_Q15))
      else $error("Normalized weights add up to more than one.");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && norm_weight_0 == ONE_Q15 |-> joint_1 == '0 && joint_2 == '0
         && joint_3 == '0 && norm_weight_1 == '0 && norm_weight_2 == '0
         && norm_weight_3 == '0)
      else $error("Full first weight with other slots occupied.");

endmodule

bind top4_influence_select_normalize tisn_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_item.valid),
   .rsp_ready     (rsp_item.ready),
   .joint_1       (rsp_item.joint_1),
   .joint_2       (rsp_item.joint_2),
   .joint_3       (rsp_item.joint_3),
   .norm_weight_0 (rsp_item.norm_weight_0),
   .norm_weight_1 (rsp_item.norm_weight_1),
   .norm_weight_2 (rsp_item.norm_weight_2),
   .norm_weight_3 (rsp_item.norm_weight_3)
);
